>>> rtl/wcma_pkg.sv
// Shared constants, register codes and control structs of the weighted moving average unit.
package wcma_pkg;

  localparam int MAX_HALF_DEF    = 31;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // A weight of one in Q8.8, and the bits it needs.
  localparam int UNIT_WEIGHT   = 256;
  localparam int UNIT_WEIGHT_W = 9;

  // Sums are kept modulo 2^64 at the very largest parameter values.
  localparam int ACC_CAP = 64;

  localparam int HALF_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WINDOW = 1'b0,
    REG_USE_WEIGHTS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/wcma_if.sv
// Handshake interfaces for the input, result and register write channels.
interface wcma_in_if #(
  parameter int SAMPLE_BITS = wcma_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = wcma_pkg::WEIGHT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [WEIGHT_BITS-1:0] weight;
  logic                          sample_valid;
  logic                          end_of_record;

  modport source (output valid, sample, weight, sample_valid, end_of_record, input ready);
  modport sink   (input valid, sample, weight, sample_valid, end_of_record, output ready);
endinterface

interface wcma_out_if #(
  parameter int SAMPLE_BITS = wcma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          no_value;
  logic                          last;

  modport source (output valid, mean, no_value, last, input ready);
  modport sink   (input valid, mean, no_value, last, output ready);
endinterface

interface wcma_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wcma_pkg::CFG_IDX_W-1:0]   index;
  logic [wcma_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/wcma_ring.sv
// Ring memory holding the recent samples and effective weights of the record.
module wcma_ring #(
  parameter int DEPTH  = 2 * wcma_pkg::MAX_HALF_DEF + 1,
  parameter int DATA_W = wcma_pkg::SAMPLE_BITS_DEF + wcma_pkg::WEIGHT_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data,
  output logic              rd_vld
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

>>> rtl/wcma_mac.sv
// Multiply-accumulate pipeline that sums weight times sample and the weights of one window.
module wcma_mac #(
  parameter int SAMPLE_BITS = wcma_pkg::SAMPLE_BITS_DEF,
  parameter int EFF_W       = wcma_pkg::WEIGHT_BITS_DEF,
  parameter int ACC_W       = 38,
  parameter int WS_W        = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wcma_pkg::mac_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [EFF_W-1:0]       weight,
  output logic signed [ACC_W-1:0]       acc,
  output logic        [WS_W-1:0]        wsum,
  output logic                          busy
);

  logic signed [SAMPLE_BITS+EFF_W:0] prod_r;
  logic        [EFF_W-1:0]           wt1_r;
  logic                              v1_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic        [WS_W-1:0]            wsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= sample * $signed({1'b0, weight});
      wt1_r  <= weight;
    end
    if (ctl.clr) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (v1_r) begin
      acc_r  <= acc_r + ACC_W'(prod_r);
      wsum_r <= wsum_r + WS_W'(wt1_r);
    end
  end

  assign acc  = acc_r;
  assign wsum = wsum_r;
  assign busy = v1_r;

endmodule

>>> rtl/wcma_div.sv
// Restoring divider that shifts in one dividend bit and yields one quotient bit per cycle.
module wcma_div #(
  parameter int QW   = wcma_pkg::SAMPLE_BITS_DEF + 1,
  parameter int WS_W = 22
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WS_W-1:0]      rem_init,
  input  logic [QW-1:0]        lo_init,
  input  logic [WS_W-1:0]      divisor,
  output logic [QW-1:0]        quotient,
  output wcma_pkg::div_stat_t  stat
);

  localparam int STEP_W = $clog2(QW);

  logic [WS_W-1:0]   rem_r;
  logic [QW-1:0]     lo_r;
  logic [WS_W-1:0]   div_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [WS_W:0]     cat;
  logic [WS_W:0]     diff;
  logic              ge;

  always_comb begin
    cat  = {rem_r, lo_r[QW-1]};
    diff = cat - {1'b0, div_r};
    ge   = (cat >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && step_r == STEP_W'(QW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The dividend register fills with quotient bits from the bottom as it empties at the top.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem_init;
      lo_r   <= lo_init;
      div_r  <= divisor;
      step_r <= '0;
    end else if (run_r) begin
      rem_r  <= ge ? diff[WS_W-1:0] : cat[WS_W-1:0];
      lo_r   <= {lo_r[QW-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign quotient  = lo_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

>>> rtl/weighted_centered_moving_average_unit.sv
// Top level of the weighted centred moving average unit: sequencer, registers and result stage.
//
//   Channel  Role    Carries
//   in_ch    sink    sample, weight, sample_valid, end_of_record
//   out_ch   source  mean, no_value, last
//   cfg_ch   sink    index, data (half_window, use_weights); always ready
//
// An input that yields no result is taken without leaving the idle state. For each result
// the ring memory gives one entry per cycle of the clipped window (up to 2h+1 entries) to
// the multiply-accumulate, and the divider makes one quotient bit per cycle. A record's
// last input flushes up to h+1 results in turn.
// Reset is synchronous and active low; it restores half_window to 1 and use_weights to 0
// and empties the record, so the ring needs no clearing pass.
// A stalled result holds the sequencer; a new request is taken once all results of the
// previous one are computed, even while the final one still waits on out_ch.
module weighted_centered_moving_average_unit #(
  parameter int MAX_HALF    = wcma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = wcma_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = wcma_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wcma_in_if.sink     in_ch,
  wcma_out_if.source  out_ch,
  wcma_cfg_if.sink    cfg_ch
);

  localparam int RING_DEPTH = 2 * MAX_HALF + 1;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int H_W        = $clog2(MAX_HALF + 1);
  localparam int EFF_W      = (WEIGHT_BITS > wcma_pkg::UNIT_WEIGHT_W) ?
                              WEIGHT_BITS : wcma_pkg::UNIT_WEIGHT_W;
  localparam int ACC_FULL   = SAMPLE_BITS + EFF_W + IDX_W;
  localparam int ACC_W      = (ACC_FULL > wcma_pkg::ACC_CAP) ? wcma_pkg::ACC_CAP : ACC_FULL;
  localparam int WS_W       = EFF_W + IDX_W;
  localparam int QW         = SAMPLE_BITS + 1;
  localparam int DATA_W     = SAMPLE_BITS + EFF_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_NEG  = 6'b000100,
    S_CHK  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [wcma_pkg::HALF_W-1:0]    half_r, half_nxt;
  logic                           use_w_r, use_w_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [IDX_W-1:0]               newest_r, newest_nxt;
  logic [CNT_W-1:0]               wcnt_r, wcnt_nxt;
  logic [H_W-1:0]                 h_r, h_nxt;
  logic [H_W-1:0]                 d_r, d_nxt;
  logic                           eor_r, eor_nxt;
  logic [IDX_W-1:0]               off_r, off_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic                           issue_r, issue_nxt;
  logic                           neg_r, neg_nxt;
  logic                           wzero_r, wzero_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [ACC_W-1:0]               mag_r, mag_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic signed [SAMPLE_BITS-1:0]  mean_r, mean_nxt;
  logic                           nov_r, nov_nxt;
  logic                           last_r, last_nxt;

  logic                           in_acc;
  logic                           out_free;
  logic [H_W-1:0]                 h_eff;
  logic [CNT_W-1:0]               cnt_inc;
  logic [H_W-1:0]                 d_eor;
  logic [IDX_W-1:0]               reach;
  logic [IDX_W-1:0]               lim;
  logic [IDX_W-1:0]               hi;
  logic [IDX_W-1:0]               idx_dec;
  logic [ACC_W-1:0]               hi_part;
  logic                           ovf_c;
  logic                           sat_pos;
  logic                           sat_neg;
  logic signed [SAMPLE_BITS-1:0]  mean_c;

  logic signed [SAMPLE_BITS-1:0]  wr_sample;
  logic [EFF_W-1:0]               wr_weight;
  logic                           wr_en;
  logic                           rd_en;
  logic [DATA_W-1:0]              rd_data;
  logic                           ring_vld;
  wcma_pkg::mac_ctl_t             mac_ctl;
  logic signed [ACC_W-1:0]        acc;
  logic [WS_W-1:0]                wsum;
  logic                           mac_busy;
  logic                           div_start;
  logic [QW-1:0]                  quotient;
  wcma_pkg::div_stat_t            div_stat;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_vld_r || out_ch.ready;

  always_comb begin
    h_eff   = (32'(half_r) > MAX_HALF) ? H_W'(MAX_HALF) : H_W'(half_r);
    cnt_inc = (cnt_r < CNT_W'(RING_DEPTH)) ? cnt_r + CNT_W'(1) : cnt_r;
    d_eor   = (CNT_W'(h_eff) < cnt_inc - CNT_W'(1)) ? h_eff : H_W'(cnt_inc - CNT_W'(1));
    // The window runs from the newest entry back to offset d+h, but not past the record start.
    reach   = IDX_W'(d_r) + IDX_W'(h_r);
    lim     = IDX_W'(wcnt_r - CNT_W'(1));
    hi      = (reach < lim) ? reach : lim;
    idx_dec = (idx_r == '0) ? IDX_W'(RING_DEPTH - 1) : idx_r - IDX_W'(1);
    hi_part = mag_r >> QW;
    ovf_c   = (hi_part >= ACC_W'(wsum));
  end

  always_comb begin
    wr_sample = in_ch.sample_valid ? in_ch.sample : '0;
    if (!in_ch.sample_valid) begin
      wr_weight = '0;
    end else if (use_w_r) begin
      wr_weight = EFF_W'(in_ch.weight);
    end else begin
      wr_weight = EFF_W'(wcma_pkg::UNIT_WEIGHT);
    end
  end

  always_comb begin
    sat_pos = ovf_r || (quotient > {2'b00, {(SAMPLE_BITS-1){1'b1}}});
    sat_neg = ovf_r || (quotient > {2'b01, {(SAMPLE_BITS-1){1'b0}}});
    if (wzero_r) begin
      mean_c = '0;
    end else if (neg_r) begin
      mean_c = sat_neg ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                         SAMPLE_BITS'(~quotient + QW'(1));
    end else begin
      mean_c = sat_pos ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : SAMPLE_BITS'(quotient);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    half_nxt    = half_r;
    use_w_nxt   = use_w_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    newest_nxt  = newest_r;
    wcnt_nxt    = wcnt_r;
    h_nxt       = h_r;
    d_nxt       = d_r;
    eor_nxt     = eor_r;
    off_nxt     = off_r;
    idx_nxt     = idx_r;
    issue_nxt   = issue_r;
    neg_nxt     = neg_r;
    wzero_nxt   = wzero_r;
    ovf_nxt     = ovf_r;
    mag_nxt     = mag_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    mean_nxt    = mean_r;
    nov_nxt     = nov_r;
    last_nxt    = last_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    mac_ctl.clr = 1'b0;
    mac_ctl.en  = ring_vld;
    div_start   = 1'b0;

    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (wcma_pkg::cfg_reg_t'(cfg_ch.index))
        wcma_pkg::REG_HALF_WINDOW: half_nxt  = cfg_ch.data[wcma_pkg::HALF_W-1:0];
        wcma_pkg::REG_USE_WEIGHTS: use_w_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wr_en      = 1'b1;
          head_nxt   = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
          newest_nxt = head_r;
          wcnt_nxt   = cnt_inc;
          h_nxt      = h_eff;
          eor_nxt    = in_ch.end_of_record;
          cnt_nxt    = in_ch.end_of_record ? '0 : cnt_inc;
          if (in_ch.end_of_record || cnt_inc > CNT_W'(h_eff)) begin
            d_nxt       = in_ch.end_of_record ? d_eor : h_eff;
            off_nxt     = '0;
            idx_nxt     = head_r;
            issue_nxt   = 1'b1;
            mac_ctl.clr = 1'b1;
            state_nxt   = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (issue_r) begin
          rd_en   = 1'b1;
          off_nxt = off_r + IDX_W'(1);
          idx_nxt = idx_dec;
          if (off_r == hi) begin
            issue_nxt = 1'b0;
          end
        end else if (!ring_vld && !mac_busy) begin
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        neg_nxt   = acc[ACC_W-1];
        mag_nxt   = acc[ACC_W-1] ? ~ACC_W'(acc) + ACC_W'(1) : ACC_W'(acc);
        wzero_nxt = (wsum == '0);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (wzero_r) begin
          state_nxt = S_EMIT;
        end else if (ovf_c) begin
          // The quotient is known to exceed the result range; skip the divider.
          ovf_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else if (!div_stat.busy) begin
          ovf_nxt   = 1'b0;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          mean_nxt    = mean_c;
          nov_nxt     = wzero_r;
          last_nxt    = eor_r && (d_r == '0);
          // Only the last input of a record flushes further results.
          if (d_r == '0 || !eor_r) begin
            state_nxt = S_IDLE;
          end else begin
            d_nxt       = d_r - H_W'(1);
            off_nxt     = '0;
            idx_nxt     = newest_r;
            issue_nxt   = 1'b1;
            mac_ctl.clr = 1'b1;
            state_nxt   = S_SUM;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      half_r    <= wcma_pkg::HALF_W'(1);
      use_w_r   <= 1'b0;
      cnt_r     <= '0;
      head_r    <= '0;
      issue_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      half_r    <= half_nxt;
      use_w_r   <= use_w_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      issue_r   <= issue_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r <= newest_nxt;
    wcnt_r   <= wcnt_nxt;
    h_r      <= h_nxt;
    d_r      <= d_nxt;
    eor_r    <= eor_nxt;
    off_r    <= off_nxt;
    idx_r    <= idx_nxt;
    neg_r    <= neg_nxt;
    wzero_r  <= wzero_nxt;
    ovf_r    <= ovf_nxt;
    mag_r    <= mag_nxt;
    mean_r   <= mean_nxt;
    nov_r    <= nov_nxt;
    last_r   <= last_nxt;
  end

  wcma_ring #(
    .DEPTH  (RING_DEPTH),
    .DATA_W (DATA_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data ({wr_sample, wr_weight}),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data),
    .rd_vld  (ring_vld)
  );

  wcma_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .EFF_W       (EFF_W),
    .ACC_W       (ACC_W),
    .WS_W        (WS_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (rd_data[DATA_W-1:EFF_W]),
    .weight (rd_data[EFF_W-1:0]),
    .acc    (acc),
    .wsum   (wsum),
    .busy   (mac_busy)
  );

  wcma_div #(
    .QW   (QW),
    .WS_W (WS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (WS_W'(hi_part)),
    .lo_init  (mag_r[QW-1:0]),
    .divisor  (wsum),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_vld_r;
  assign out_ch.mean     = mean_r;
  assign out_ch.no_value = nov_r;
  assign out_ch.last     = last_r;

endmodule

>>> rtl/wcma_chk.sv
// Port-level checks of the weighted moving average unit, bound to its top level.
module wcma_chk #(
  parameter int SAMPLE_BITS = wcma_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_eor,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_mean,
  input logic                   out_no_value,
  input logic                   out_last,
  input logic                   cfg_ready
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) &&
                                $stable(out_no_value) && $stable(out_last))
    else $error("result changed while stalled");

  // The last input of a record always causes at least one result, so the unit goes busy.
  a_eor_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_eor |=> !in_ready)
    else $error("end of record did not start a flush");

  // The input side only goes busy because of a request just taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without a request");

  // Register writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind weighted_centered_moving_average_unit wcma_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wcma_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_eor       (in_ch.end_of_record),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_mean     (out_ch.mean),
  .out_no_value (out_ch.no_value),
  .out_last     (out_ch.last),
  .cfg_ready    (cfg_ch.ready)
);
